FILE: sv/sdrm_pkg.sv
// shared types and constants for the slice difference rectangle merger
`default_nettype none

package sdrm_pkg;

    localparam int ROW_BITS   = 8;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int RESULT_CAP = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] ROWS_IN_USE_RESET = 4'd8;
    localparam logic [CFG_W-1:0] COLS_IN_USE_RESET = 4'd8;

    typedef struct packed {
        logic [7:0] row_first_plane;
        logic [7:0] row_second_plane;
        logic [7:0] plane_position;
        logic       last_row;
    } item_t;

    typedef struct packed {
        logic [2:0] row_start;
        logic [2:0] col_start;
        logic [3:0] row_end;
        logic [3:0] col_end;
        logic [7:0] face_plane;
        logic       facing_up;
        logic       last_face;
    } face_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GROW_COL,
        ST_GROW_ROW,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic mark;
    } store_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/sdrm_plane_store.sv
// plane row stores and covered-cell map with one row read port
`default_nettype none

module sdrm_plane_store #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sdrm_pkg::store_ctrl_t ctrl,
    input  wire logic [RI-1:0]         load_idx,
    input  wire logic [MAX_COLS-1:0]   load_first,
    input  wire logic [MAX_COLS-1:0]   load_second,
    input  wire logic [RI-1:0]         rd_idx,
    input  wire logic [MAX_COLS-1:0]   mark_mask,
    output logic      [MAX_COLS-1:0]   rd_first,
    output logic      [MAX_COLS-1:0]   rd_diff
);

    logic [MAX_COLS-1:0] first_reg  [MAX_ROWS];
    logic [MAX_COLS-1:0] second_reg [MAX_ROWS];
    logic [MAX_COLS-1:0] cover_reg  [MAX_ROWS];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            first_reg[load_idx]  <= load_first;
            second_reg[load_idx] <= load_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                cover_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                cover_reg[i] <= '0;
            end
        end
        else if (ctrl.mark)
        begin
            cover_reg[rd_idx] <= cover_reg[rd_idx] | mark_mask;
        end
    end

    // differing cells of the addressed row that are not yet covered
    assign rd_first = first_reg[rd_idx];
    assign rd_diff  = (first_reg[rd_idx] ^ second_reg[rd_idx]) & ~cover_reg[rd_idx];

endmodule

`default_nettype wire

FILE: sv/sdrm_seq.sv
// load and greedy scan sequencer with pending face and output register
`default_nettype none

module sdrm_seq #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [sdrm_pkg::CFG_W-1:0]   rows_in_use,
    input  wire logic [sdrm_pkg::CFG_W-1:0]   cols_in_use,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire sdrm_pkg::item_t              item,
    output logic                              face_valid,
    input  wire logic                         face_ready,
    output sdrm_pkg::face_t                   face,
    output sdrm_pkg::store_ctrl_t             ctrl,
    output logic [RI-1:0]                     load_idx,
    output logic [MAX_COLS-1:0]               load_first,
    output logic [MAX_COLS-1:0]               load_second,
    output logic [RI-1:0]                     rd_idx,
    output logic [MAX_COLS-1:0]               mark_mask,
    input  wire logic [MAX_COLS-1:0]          rd_first,
    input  wire logic [MAX_COLS-1:0]          rd_diff
);

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int CI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(sdrm_pkg::RESULT_CAP + 1);
    localparam int XW = MAX_COLS + sdrm_pkg::ROW_BITS;

    sdrm_pkg::state_t state_reg, state_next;

    logic [RW-1:0]       cnt_reg, cnt_next;
    logic [7:0]          pos_reg, pos_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [RW-1:0]       r2_reg, r2_next;
    logic [CW-1:0]       c2_reg, c2_next;
    logic                up_reg, up_next;
    logic [MAX_COLS-1:0] span_reg, span_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [RW-1:0]       pr_reg, pr_next;
    logic [CW-1:0]       pc_reg, pc_next;
    logic [RW-1:0]       pr2_reg, pr2_next;
    logic [CW-1:0]       pc2_reg, pc2_next;
    logic                pup_reg, pup_next;
    logic                face_valid_reg, face_valid_next;
    sdrm_pkg::face_t     face_reg, face_next;

    logic [RW-1:0]       nr;
    logic [CW-1:0]       nc;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] span_new;
    logic [MAX_COLS-1:0] side;
    logic [MAX_COLS-1:0] usable;
    logic                out_free;
    logic                scan_row_done;
    logic                scan_col_done;
    logic                seed_hit;
    logic                grow_col_ok;
    logic                grow_row_ok;
    logic [NW-1:0]       n_inc;
    logic                cap_hit;
    logic                push_go;
    logic                accept;
    logic [XW-1:0]       ext_first;
    logic [XW-1:0]       ext_second;
    logic [RW+3:0]       pr_ext;
    logic [RW+3:0]       pr2_ext;
    logic [CW+3:0]       pc_ext;
    logic [CW+3:0]       pc2_ext;
    sdrm_pkg::face_t     face_pend;

    // register values above the storage size saturate
    assign nr = ({28'd0, rows_in_use} > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_in_use);
    assign nc = ({28'd0, cols_in_use} > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_in_use);

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            col_mask[i] = (32'(i) < 32'(nc));
            span_new[i] = (32'(i) >= 32'(c_reg)) && (32'(i) < 32'(c2_reg));
        end
    end

    // shared row test: one store row against the seed's facing
    assign side     = up_reg ? rd_first : ~rd_first;
    assign usable   = rd_diff & side & col_mask;
    assign out_free = !face_valid_reg || face_ready;

    assign scan_row_done = (r_reg >= nr);
    assign scan_col_done = (c_reg >= nc);
    assign seed_hit      = rd_diff[c_reg[CI-1:0]];
    assign grow_col_ok   = (c2_reg < nc) && usable[c2_reg[CI-1:0]];
    assign grow_row_ok   = (r2_reg < nr) && ((usable & span_reg) == span_reg);
    assign n_inc         = n_reg + NW'(1);
    assign cap_hit       = (n_inc == NW'(sdrm_pkg::RESULT_CAP));
    assign push_go       = !pend_valid_reg || out_free;
    assign accept        = item_valid && item_ready;

    assign ext_first  = {{MAX_COLS{1'b0}}, item.row_first_plane};
    assign ext_second = {{MAX_COLS{1'b0}}, item.row_second_plane};
    assign load_first  = ext_first[MAX_COLS-1:0];
    assign load_second = ext_second[MAX_COLS-1:0];
    assign load_idx    = cnt_reg[RI-1:0];

    assign pr_ext  = {4'd0, pr_reg};
    assign pr2_ext = {4'd0, pr2_reg};
    assign pc_ext  = {4'd0, pc_reg};
    assign pc2_ext = {4'd0, pc2_reg};

    always_comb
    begin
        face_pend.row_start  = pr_ext[2:0];
        face_pend.col_start  = pc_ext[2:0];
        face_pend.row_end    = pr2_ext[3:0];
        face_pend.col_end    = pc2_ext[3:0];
        face_pend.face_plane = pos_reg;
        face_pend.facing_up  = pup_reg;
        face_pend.last_face  = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdrm_pkg::ST_IDLE:
            begin
                if (item_valid && item.last_row)
                    state_next = sdrm_pkg::ST_SCAN;
            end
            sdrm_pkg::ST_SCAN:
            begin
                if (scan_row_done)
                    state_next = sdrm_pkg::ST_FLUSH;
                else if (!scan_col_done && seed_hit)
                    state_next = sdrm_pkg::ST_GROW_COL;
            end
            sdrm_pkg::ST_GROW_COL:
            begin
                if (!grow_col_ok)
                    state_next = sdrm_pkg::ST_GROW_ROW;
            end
            sdrm_pkg::ST_GROW_ROW:
            begin
                if (!grow_row_ok)
                    state_next = sdrm_pkg::ST_PUSH;
            end
            sdrm_pkg::ST_PUSH:
            begin
                if (push_go)
                    state_next = cap_hit ? sdrm_pkg::ST_FLUSH : sdrm_pkg::ST_SCAN;
            end
            sdrm_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = sdrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sdrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready      = 1'b0;
        ctrl            = '0;
        rd_idx          = r_reg[RI-1:0];
        mark_mask       = span_new;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        n_next          = n_reg;
        r2_next         = r2_reg;
        c2_next         = c2_reg;
        up_next         = up_reg;
        span_next       = span_reg;
        pend_valid_next = pend_valid_reg;
        pr_next         = pr_reg;
        pc_next         = pc_reg;
        pr2_next        = pr2_reg;
        pc2_next        = pc2_reg;
        pup_next        = pup_reg;
        face_next       = face_reg;
        face_valid_next = face_valid_reg && !face_ready;

        case (state_reg)
            sdrm_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    // rows beyond the store are dropped
                    if (cnt_reg < RW'(MAX_ROWS))
                    begin
                        ctrl.load = 1'b1;
                        cnt_next  = cnt_reg + RW'(1);
                    end
                    pos_next = item.plane_position;
                    if (item.last_row)
                    begin
                        cnt_next   = '0;
                        ctrl.clear = 1'b1;
                        r_next     = '0;
                        c_next     = '0;
                        n_next     = '0;
                    end
                end
            end
            sdrm_pkg::ST_SCAN:
            begin
                if (!scan_row_done)
                begin
                    if (scan_col_done)
                    begin
                        r_next = r_reg + RW'(1);
                        c_next = '0;
                    end
                    else if (seed_hit)
                    begin
                        up_next = rd_first[c_reg[CI-1:0]];
                        c2_next = c_reg + CW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end
            sdrm_pkg::ST_GROW_COL:
            begin
                if (grow_col_ok)
                begin
                    c2_next = c2_reg + CW'(1);
                end
                else
                begin
                    ctrl.mark = 1'b1;
                    span_next = span_new;
                    r2_next   = r_reg + RW'(1);
                end
            end
            sdrm_pkg::ST_GROW_ROW:
            begin
                rd_idx    = r2_reg[RI-1:0];
                mark_mask = span_reg;
                if (grow_row_ok)
                begin
                    ctrl.mark = 1'b1;
                    r2_next   = r2_reg + RW'(1);
                end
            end
            sdrm_pkg::ST_PUSH:
            begin
                // the previous face goes out only once a later one is known
                if (push_go)
                begin
                    if (pend_valid_reg)
                    begin
                        face_next       = face_pend;
                        face_valid_next = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pr_next         = r_reg;
                    pc_next         = c_reg;
                    pr2_next        = r2_reg;
                    pc2_next        = c2_reg;
                    pup_next        = up_reg;
                    n_next          = n_inc;
                    c_next          = c_reg + CW'(1);
                end
            end
            sdrm_pkg::ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    face_next           = face_pend;
                    face_next.last_face = 1'b1;
                    face_valid_next     = 1'b1;
                    pend_valid_next     = 1'b0;
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdrm_pkg::ST_IDLE;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            face_valid_reg <= face_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg   <= r2_next;
        c2_reg   <= c2_next;
        up_reg   <= up_next;
        span_reg <= span_next;
        pr_reg   <= pr_next;
        pc_reg   <= pc_next;
        pr2_reg  <= pr2_next;
        pc2_reg  <= pc2_next;
        pup_reg  <= pup_next;
        face_reg <= face_next;
    end

    assign face_valid = face_valid_reg;
    assign face       = face_reg;

endmodule

`default_nettype wire

FILE: sv/slice_difference_rect_merger.sv
// row words load into the stores while idle; ready stays high while non-last row words arrive
// the last row starts the scan: it tests each cell in turn, steps from row to row, grows each seed
// across columns and then down rows, pushes each face, and at the end flushes the pending face
// the scan walks the stores through one shared row read and bit test unit
// faces leave through an output register; a new word is not taken during the scan
// reset clears control, counts and covered map, registers go to 8 and 8; row stores stay undefined
`default_nettype none

module slice_difference_rect_merger #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [sdrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sdrm_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire sdrm_pkg::item_t                  item,
    output logic                                  face_valid,
    input  wire logic                             face_ready,
    output sdrm_pkg::face_t                       face
);

    localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [sdrm_pkg::CFG_W-1:0] rows_reg, rows_next;
    logic [sdrm_pkg::CFG_W-1:0] cols_reg, cols_next;

    sdrm_pkg::store_ctrl_t ctrl;
    logic [RI-1:0]         load_idx;
    logic [MAX_COLS-1:0]   load_first;
    logic [MAX_COLS-1:0]   load_second;
    logic [RI-1:0]         rd_idx;
    logic [MAX_COLS-1:0]   mark_mask;
    logic [MAX_COLS-1:0]   rd_first;
    logic [MAX_COLS-1:0]   rd_diff;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sdrm_pkg::CFG_ROWS_IN_USE: rows_next = cfg_data;
                sdrm_pkg::CFG_COLS_IN_USE: cols_next = cfg_data;
                default:
                begin
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= sdrm_pkg::ROWS_IN_USE_RESET;
            cols_reg <= sdrm_pkg::COLS_IN_USE_RESET;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    sdrm_plane_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .load_idx    (load_idx),
        .load_first  (load_first),
        .load_second (load_second),
        .rd_idx      (rd_idx),
        .mark_mask   (mark_mask),
        .rd_first    (rd_first),
        .rd_diff     (rd_diff)
    );

    sdrm_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .face_valid  (face_valid),
        .face_ready  (face_ready),
        .face        (face),
        .ctrl        (ctrl),
        .load_idx    (load_idx),
        .load_first  (load_first),
        .load_second (load_second),
        .rd_idx      (rd_idx),
        .mark_mask   (mark_mask),
        .rd_first    (rd_first),
        .rd_diff     (rd_diff)
    );

endmodule

`default_nettype wire

FILE: sv/sdrm_checker.sv
// port-level checker for the rectangle merger and its bind
`default_nettype none

module sdrm_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            item_valid,
    input wire logic            item_ready,
    input wire sdrm_pkg::item_t item,
    input wire logic            face_valid,
    input wire logic            face_ready,
    input wire sdrm_pkg::face_t face
);

    // a stalled face word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && !face_ready |=> face_valid && $stable(face))
    else $error("face word changed while stalled");

    // ready stays high after a non-last row
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !item.last_row |=> item_ready)
    else $error("not ready after a plain row word");

    // the last row starts the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last_row |=> !item_ready)
    else $error("ready right after the last row word");

    // every face covers at least one cell
    assert property (@(posedge clk) disable iff (!rst_n)
        face_valid |-> ({1'b0, face.row_start} < face.row_end)
                    && ({1'b0, face.col_start} < face.col_end))
    else $error("empty rectangle emitted");

endmodule

bind slice_difference_rect_merger sdrm_checker u_sdrm_checker (.*);

`default_nettype wire
